>>> sv/expression_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// Expression token lexer assertion macros
// Shared property forms for the lexer's checker.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define ETL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lexer check failed");

// next-cycle implication
`define ETL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lexer check failed");

`endif

>>> sv/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// Types and constants shared by the expression token lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int SLOTS = 3;

	// token types
	localparam logic [3:0] TOK_PLUS  = 4'd0;
	localparam logic [3:0] TOK_MINUS = 4'd1;
	localparam logic [3:0] TOK_DIV   = 4'd2;
	localparam logic [3:0] TOK_MUL   = 4'd3;
	localparam logic [3:0] TOK_LPAR  = 4'd4;
	localparam logic [3:0] TOK_RPAR  = 4'd5;
	localparam logic [3:0] TOK_POWER = 4'd6;
	localparam logic [3:0] TOK_INT   = 4'd7;
	localparam logic [3:0] TOK_REAL  = 4'd8;
	localparam logic [3:0] TOK_ID    = 4'd9;
	localparam logic [3:0] TOK_END   = 4'd10;
	localparam logic [3:0] TOK_ERROR = 4'd11;

	// error kinds
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_DUP_DOT = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN = 2'd2;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_REAL = 2'd2,
		MODE_ID   = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [3:0]          token_type;
		logic [POS_BITS-1:0] start_pos;
		logic [POS_BITS-1:0] end_pos;
		logic [POS_BITS-1:0] line_num;
		logic [1:0]          error_kind;
		logic                last_token;
	} token_item_t;

	// up to three tokens caused by one byte, in emission order
	typedef struct packed {
		token_item_t [SLOTS-1:0] tok;
		logic [SLOTS-1:0]        mask;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t data;
	} queue_wr_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} queue_rd_t;

endpackage

>>> sv/etl_front.sv
// ----------------------------------------------------------------------------
// etl_front
// Byte classifier and scan state; builds the token bundle for each byte.
// ----------------------------------------------------------------------------
module etl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	input  etl_pkg::char_item_t char_item,
	input  logic                queue_full,
	output etl_pkg::queue_wr_t  wr
);

	logic [etl_pkg::POS_BITS-1:0] pos_q, line_q, pstart_q, pline_q;
	etl_pkg::scan_mode_t          mode_q;
	logic                         halted_q;

	logic [etl_pkg::POS_BITS-1:0] pos_n, line_n, pstart_n, pline_n;
	etl_pkg::scan_mode_t          mode_n;
	logic                         halted_n;
	logic                         accept;
	etl_pkg::bundle_t             bnd;

	function automatic logic [etl_pkg::POS_BITS-1:0] sat_inc(
		input logic [etl_pkg::POS_BITS-1:0] v);
		return (v == etl_pkg::POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [3:0] mode_type(input etl_pkg::scan_mode_t m);
		logic [3:0] t;
		case (m)
			etl_pkg::MODE_INT:  t = etl_pkg::TOK_INT;
			etl_pkg::MODE_REAL: t = etl_pkg::TOK_REAL;
			default:            t = etl_pkg::TOK_ID;
		endcase
		return t;
	endfunction

	function automatic etl_pkg::token_item_t mk_tok(
		input logic [3:0]                   ty,
		input logic [etl_pkg::POS_BITS-1:0] s,
		input logic [etl_pkg::POS_BITS-1:0] e,
		input logic [etl_pkg::POS_BITS-1:0] l,
		input logic [1:0]                   ek,
		input logic                         lt);
		etl_pkg::token_item_t t;
		t.token_type = ty;
		t.start_pos  = s;
		t.end_pos    = e;
		t.line_num   = l;
		t.error_kind = ek;
		t.last_token = lt;
		return t;
	endfunction

	assign accept = char_valid && !queue_full;

	always_comb begin
		logic [7:0] c;
		logic       is_dig, is_alp, used, is_op;
		logic [3:0] op;

		c      = char_item.char_code;
		is_dig = c inside {[etl_pkg::CH_ZERO:etl_pkg::CH_NINE]};
		is_alp = c inside {[etl_pkg::CH_UPPER_A:etl_pkg::CH_UPPER_Z],
			[etl_pkg::CH_LOWER_A:etl_pkg::CH_LOWER_Z]};
		used   = 1'b0;
		is_op  = 1'b1;
		case (c)
			etl_pkg::CH_PLUS:  op = etl_pkg::TOK_PLUS;
			etl_pkg::CH_MINUS: op = etl_pkg::TOK_MINUS;
			etl_pkg::CH_SLASH: op = etl_pkg::TOK_DIV;
			etl_pkg::CH_STAR:  op = etl_pkg::TOK_MUL;
			etl_pkg::CH_LPAR:  op = etl_pkg::TOK_LPAR;
			etl_pkg::CH_RPAR:  op = etl_pkg::TOK_RPAR;
			etl_pkg::CH_CARET: op = etl_pkg::TOK_POWER;
			default: begin
				op    = etl_pkg::TOK_ERROR;
				is_op = 1'b0;
			end
		endcase

		pos_n    = sat_inc(pos_q);
		line_n   = line_q;
		pstart_n = pstart_q;
		pline_n  = pline_q;
		mode_n   = mode_q;
		halted_n = halted_q;
		bnd      = '0;

		if (!halted_q) begin
			if (mode_q == etl_pkg::MODE_INT || mode_q == etl_pkg::MODE_REAL) begin
				if (is_dig) begin
					used = 1'b1;
				end else if (c == etl_pkg::CH_DOT) begin
					used = 1'b1;
					if (mode_q == etl_pkg::MODE_INT) begin
						mode_n = etl_pkg::MODE_REAL;
					end else begin
						bnd.tok[0]  = mk_tok(etl_pkg::TOK_ERROR, pstart_q, pos_q, pline_q,
							etl_pkg::ERR_DUP_DOT, 1'b0);
						bnd.mask[0] = 1'b1;
						mode_n      = etl_pkg::MODE_IDLE;
						halted_n    = 1'b1;
					end
				end
			end else if (mode_q == etl_pkg::MODE_ID) begin
				used = is_alp || is_dig || (c == etl_pkg::CH_UNDER);
			end

			if (!used && mode_q != etl_pkg::MODE_IDLE) begin
				bnd.tok[0]  = mk_tok(mode_type(mode_q), pstart_q, pos_q, pline_q,
					etl_pkg::ERR_NONE, 1'b0);
				bnd.mask[0] = 1'b1;
				mode_n      = etl_pkg::MODE_IDLE;
			end

			if (!used) begin
				if (c == etl_pkg::CH_SPACE || c == etl_pkg::CH_TAB) begin
					line_n = line_q;
				end else if (c == etl_pkg::CH_CR || c == etl_pkg::CH_LF) begin
					line_n = sat_inc(line_q);
				end else if (is_op) begin
					bnd.tok[1]  = mk_tok(op, pos_q, sat_inc(pos_q), line_q,
						etl_pkg::ERR_NONE, 1'b0);
					bnd.mask[1] = 1'b1;
				end else if (is_dig || is_alp) begin
					mode_n   = is_dig ? etl_pkg::MODE_INT : etl_pkg::MODE_ID;
					pstart_n = pos_q;
					pline_n  = line_q;
				end else begin
					bnd.tok[1]  = mk_tok(etl_pkg::TOK_ERROR, pos_q, pos_q, line_q,
						etl_pkg::ERR_UNKNOWN, 1'b0);
					bnd.mask[1] = 1'b1;
					halted_n    = 1'b1;
				end
			end
		end

		if (char_item.last_char) begin
			// slot 1 is free here: an operator byte leaves the mode idle
			if (!halted_n && mode_n != etl_pkg::MODE_IDLE) begin
				bnd.tok[1]  = mk_tok(mode_type(mode_n), pstart_n, pos_n, pline_n,
					etl_pkg::ERR_NONE, 1'b0);
				bnd.mask[1] = 1'b1;
			end
			bnd.tok[2]  = mk_tok(etl_pkg::TOK_END, pos_n, pos_n, line_n,
				etl_pkg::ERR_NONE, 1'b1);
			bnd.mask[2] = 1'b1;
			pos_n    = '0;
			line_n   = etl_pkg::POS_BITS'(1);
			pstart_n = '0;
			pline_n  = etl_pkg::POS_BITS'(1);
			mode_n   = etl_pkg::MODE_IDLE;
			halted_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			line_q   <= etl_pkg::POS_BITS'(1);
			pstart_q <= '0;
			pline_q  <= etl_pkg::POS_BITS'(1);
			mode_q   <= etl_pkg::MODE_IDLE;
			halted_q <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			line_q   <= line_n;
			pstart_q <= pstart_n;
			pline_q  <= pline_n;
			mode_q   <= mode_n;
			halted_q <= halted_n;
		end
	end

	assign wr.push = accept && (|bnd.mask);
	assign wr.data = bnd;

endmodule

>>> sv/etl_queue.sv
// ----------------------------------------------------------------------------
// etl_queue
// Small FIFO of token bundles between classifier and token emitter.
// ----------------------------------------------------------------------------
module etl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  etl_pkg::queue_wr_t wr,
	input  logic               pop,
	output logic               full,
	output etl_pkg::queue_rd_t rd
);

	etl_pkg::bundle_t                store_q [etl_pkg::QUEUE_DEPTH];
	logic [etl_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [etl_pkg::QCNT_BITS-1:0]   cnt_q;
	logic                            do_push, do_pop;

	function automatic logic [etl_pkg::QPTR_BITS-1:0] ptr_inc(
		input logic [etl_pkg::QPTR_BITS-1:0] p);
		return (p == etl_pkg::QPTR_BITS'(etl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == etl_pkg::QCNT_BITS'(etl_pkg::QUEUE_DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = store_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/etl_back.sv
// ----------------------------------------------------------------------------
// etl_back
// Token emitter: walks a bundle slot by slot into the output register.
// ----------------------------------------------------------------------------
module etl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  etl_pkg::queue_rd_t   rd,
	output logic                 pop,
	output logic                 token_valid,
	input  logic                 token_stall,
	output etl_pkg::token_item_t token_item
);

	etl_pkg::bundle_t               cur_q;
	logic [etl_pkg::SLOTS-1:0]      rem_q;
	logic                           out_valid_q;
	etl_pkg::token_item_t           out_q;

	logic                           adv;
	logic [etl_pkg::SLOTS-1:0]      pick, rem_after;
	etl_pkg::token_item_t           sel;

	always_comb begin
		adv = !out_valid_q || !token_stall;
		if (rem_q[0]) begin
			pick = 3'b001;
			sel  = cur_q.tok[0];
		end else if (rem_q[1]) begin
			pick = 3'b010;
			sel  = cur_q.tok[1];
		end else begin
			pick = 3'b100;
			sel  = cur_q.tok[2];
		end
		rem_after = adv ? (rem_q & ~pick) : rem_q;
		pop       = (rem_after == '0) && rd.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= |rem_q;
			end
			rem_q <= pop ? rd.data.mask : rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (|rem_q)) begin
			out_q <= sel;
		end
		if (pop) begin
			cur_q <= rd.data;
		end
	end

	assign token_valid = out_valid_q;
	assign token_item  = out_q;

endmodule

>>> sv/expression_token_lexer.sv
// ----------------------------------------------------------------------------
// expression_token_lexer
// Streaming lexer for arithmetic expressions, one text byte per item.
// ----------------------------------------------------------------------------
// Path: a byte's tokens pass the bundle queue, the emitter's bundle register
// and the output register. Throughput: one byte per cycle while char_stall is low;
// a byte's up to 3 tokens leave one at a time, absorbed by a 4-entry bundle queue.
// Reset: scan state returns to position 0, line 1, idle; queue and output
// register are emptied. Each final byte also restores the scan state.
module expression_token_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  etl_pkg::char_item_t  char_item,
	output logic                 token_valid,
	input  logic                 token_stall,
	output etl_pkg::token_item_t token_item
);

	etl_pkg::queue_wr_t wr;
	etl_pkg::queue_rd_t rd;
	logic               full;
	logic               pop;

	assign char_stall = full;

	etl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_item  (char_item),
		.queue_full (full),
		.wr         (wr)
	);

	etl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.full   (full),
		.rd     (rd)
	);

	etl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (rd),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

>>> sv/etl_checker.sv
// ----------------------------------------------------------------------------
// etl_checker
// Port-level checks on the lexer's token stream.
// ----------------------------------------------------------------------------
`include "expression_token_lexer_assert.svh"

module etl_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 char_valid,
	input logic                 char_stall,
	input etl_pkg::char_item_t  char_item,
	input logic                 token_valid,
	input logic                 token_stall,
	input etl_pkg::token_item_t token_item
);

	logic tok_held, tok_end, end_ok, tok_plain, tok_op, op_span_ok, in_known;

	assign tok_held   = token_valid && token_stall;
	assign tok_end    = token_valid && token_item.last_token;
	assign end_ok     = (token_item.token_type == etl_pkg::TOK_END)
		&& (token_item.start_pos == token_item.end_pos);
	assign tok_plain  = token_valid && (token_item.token_type != etl_pkg::TOK_ERROR);
	assign tok_op     = token_valid && (token_item.token_type <= etl_pkg::TOK_POWER);
	assign op_span_ok = (token_item.end_pos == token_item.start_pos + etl_pkg::POS_BITS'(1))
		|| ((token_item.start_pos == etl_pkg::POS_MAX)
		&& (token_item.end_pos == token_item.start_pos));
	assign in_known   = !$isunknown({char_stall, char_item});

	`ETL_ASSERT_NEXT(a_hold, clk, arst_n, tok_held, token_valid && $stable(token_item))
	`ETL_ASSERT_NOW(a_end_flag, clk, arst_n, tok_end, end_ok)
	`ETL_ASSERT_NOW(a_err_kind, clk, arst_n, tok_plain, token_item.error_kind == etl_pkg::ERR_NONE)
	`ETL_ASSERT_NOW(a_op_span, clk, arst_n, tok_op, op_span_ok)
	`ETL_ASSERT_NOW(a_in_known, clk, arst_n, char_valid, in_known)

endmodule

bind expression_token_lexer etl_checker u_checker (.*);
